[rtl/core/euclidean_depth_point_assert.svh]
// Assertion macros shared by the depth point design.
`ifndef EUCLIDEAN_DEPTH_POINT_ASSERT_SVH
`define EUCLIDEAN_DEPTH_POINT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define EDP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("edp assertion failed");

// Next-cycle implication, disabled while reset is low.
`define EDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("edp assertion failed");

`endif

[rtl/core/edp_pkg.sv]
`timescale 1ns / 1ps
package edp_pkg;

  localparam int COORD_W   = 16;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int MAG_W     = 16;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int SUM_W     = SQ_W + 2;
  localparam int FRAC_W    = 16;
  localparam int RAD_W     = SUM_W + FRAC_W;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int REM_W     = ROOT_W + 3;
  localparam int DEPTH_W   = 17;
  localparam int QUO_W     = DEPTH_W;
  localparam int DREM_W    = ROOT_W + 1;
  localparam int NUM_LOG2  = 24;
  localparam int DIMS_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_CENTERS = 4;

  localparam logic [ROOT_W-1:0]  ONE_Q8     = ROOT_W'(256);
  localparam logic [ROOT_W-1:0]  DIST_MAX   = ROOT_W'(33553920);
  localparam logic [DEPTH_W-1:0] DEPTH_ONE  = DEPTH_W'(65536);
  localparam logic [DREM_W-1:0]  DIV_SEED   = DREM_W'(1) << (NUM_LOG2 - QUO_W);

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_DIMS = 3'd4;

  localparam logic [DIMS_W-1:0] DIMS_RESET = 3'd4;

  typedef struct packed {
    logic             vld;
    logic [SUM_W-1:0] sum;
  } sum_item_t;

  typedef struct packed {
    logic              vld;
    logic [ROOT_W-1:0] root;
  } dist_item_t;

endpackage

[rtl/core/euclidean_depth_point.sv]
`timescale 1ns / 1ps
// Channel   Handshake               Payload
// input     start / busy            in_coord_0 .. in_coord_3
// result    out_valid (strobe)      out_distance_q8, out_depth_q16
// config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One point enters every cycle while busy is low; each result follows its point through
// the lane registers, the sum register, the 25-stage square root and the 17-stage divider.
// Reset is synchronous, active low; busy, registered from reset, is high during reset and in the cycle after it.
// The result strobe lasts one cycle and cannot be held off; cfg_ready is always high.
module euclidean_depth_point #(
  parameter int MAX_DIMS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [edp_pkg::COORD_W-1:0]  in_coord_0,
  input  logic signed [edp_pkg::COORD_W-1:0]  in_coord_1,
  input  logic signed [edp_pkg::COORD_W-1:0]  in_coord_2,
  input  logic signed [edp_pkg::COORD_W-1:0]  in_coord_3,
  output logic                                out_valid,
  output logic [edp_pkg::ROOT_W-1:0]          out_distance_q8,
  output logic [edp_pkg::DEPTH_W-1:0]         out_depth_q16,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [edp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [edp_pkg::COORD_W-1:0]         cfg_data
);
  import edp_pkg::*;

  localparam int LATENCY = 3 + ROOT_W + 1 + QUO_W;

  logic                       busy_r;
  logic                       accept;
  logic signed [COORD_W-1:0]  center_r [NUM_CENTERS];
  logic [DIMS_W-1:0]          dims_r;
  logic [DIMS_W-1:0]          dims_eff;
  logic signed [COORD_W-1:0]  coord_w [NUM_CENTERS];
  logic [SQ_W-1:0]            sq_w [MAX_DIMS];
  logic                       vld0_r;
  logic                       vld1_r;
  logic                       sum_vld_r;
  logic [SUM_W-1:0]           sum_r;
  logic [SUM_W-1:0]           sum_nxt;
  sum_item_t                  sum_item;
  dist_item_t                 dist_item;

  assign busy      = busy_r;
  assign accept    = start & ~busy_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    busy_r <= ~rst_n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CENTERS; i++) begin
        center_r[i] <= '0;
      end
      dims_r <= DIMS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CENTER_0:    center_r[0] <= cfg_data;
        CFG_CENTER_1:    center_r[1] <= cfg_data;
        CFG_CENTER_2:    center_r[2] <= cfg_data;
        CFG_CENTER_3:    center_r[3] <= cfg_data;
        CFG_ACTIVE_DIMS: dims_r      <= cfg_data[DIMS_W-1:0];
        default: ;
      endcase
    end
  end

  assign dims_eff = (dims_r > DIMS_W'(MAX_DIMS)) ? DIMS_W'(MAX_DIMS) : dims_r;

  assign coord_w[0] = in_coord_0;
  assign coord_w[1] = in_coord_1;
  assign coord_w[2] = in_coord_2;
  assign coord_w[3] = in_coord_3;

  for (genvar i = 0; i < MAX_DIMS; i++) begin : g_lane
    edp_lane u_lane (
      .clk    (clk),
      .coord  (coord_w[i]),
      .center (center_r[i]),
      .active (DIMS_W'(i) < dims_eff),
      .sq     (sq_w[i])
    );
  end

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < MAX_DIMS; i++) begin
      sum_nxt = sum_nxt + SUM_W'(sq_w[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r    <= 1'b0;
      vld1_r    <= 1'b0;
      sum_vld_r <= 1'b0;
    end else begin
      vld0_r    <= accept;
      vld1_r    <= vld0_r;
      sum_vld_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  assign sum_item.vld = sum_vld_r;
  assign sum_item.sum = sum_r;

  edp_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (sum_item),
    .out_item (dist_item)
  );

  edp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (dist_item),
    .out_valid (out_valid),
    .out_dist  (out_distance_q8),
    .out_depth (out_depth_q16)
  );

`include "euclidean_depth_point_assert.svh"

  `EDP_ASSERT_NOW(a_out_from_accept, clk, rst_n, out_valid, $past(accept, LATENCY))
  `EDP_ASSERT_NOW(a_dist_range, clk, rst_n, out_valid, out_distance_q8 <= DIST_MAX)
  `EDP_ASSERT_NOW(a_depth_range, clk, rst_n, out_valid, out_depth_q16 <= DEPTH_ONE)
  `EDP_ASSERT_NOW(a_zero_dist, clk, rst_n, out_valid && (out_distance_q8 == '0),
                  out_depth_q16 == DEPTH_ONE)
  `EDP_ASSERT_NEXT(a_sum_follows, clk, rst_n, vld1_r, sum_item.vld)

endmodule

[rtl/core/edp_lane.sv]
`timescale 1ns / 1ps
module edp_lane (
  input  logic                              clk,
  input  logic signed [edp_pkg::COORD_W-1:0] coord,
  input  logic signed [edp_pkg::COORD_W-1:0] center,
  input  logic                              active,
  output logic [edp_pkg::SQ_W-1:0]          sq
);
  import edp_pkg::*;

  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        absd;
  logic [MAG_W-1:0]         mag_r;
  logic [MAG_W-1:0]         mag_nxt;
  logic [SQ_W-1:0]          sq_r;
  logic [SQ_W-1:0]          sq_nxt;

  always_comb begin
    diff    = DIFF_W'(coord) - DIFF_W'(center);
    absd    = diff[DIFF_W-1] ? (-diff) : diff;
    mag_nxt = active ? absd[MAG_W-1:0] : '0;
    sq_nxt  = SQ_W'(mag_r) * SQ_W'(mag_r);
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    sq_r  <= sq_nxt;
  end

  assign sq = sq_r;

endmodule

[rtl/core/edp_sqrt.sv]
`timescale 1ns / 1ps
module edp_sqrt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  edp_pkg::sum_item_t     in_item,
  output edp_pkg::dist_item_t    out_item
);
  import edp_pkg::*;

  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [RAD_W-1:0]  rad_r  [ROOT_W];
  logic              vld_r  [ROOT_W];

  logic [REM_W-1:0]  rem_in  [ROOT_W];
  logic [ROOT_W-1:0] root_in [ROOT_W];
  logic [RAD_W-1:0]  rad_in  [ROOT_W];
  logic              vld_in  [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    logic [REM_W-1:0]  pulled;
    logic [REM_W-1:0]  trial;
    logic              ge;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (j == 0) begin : g_first
      assign rem_in[j]  = '0;
      assign root_in[j] = '0;
      assign rad_in[j]  = {in_item.sum, {FRAC_W{1'b0}}};
      assign vld_in[j]  = in_item.vld;
    end else begin : g_next
      assign rem_in[j]  = rem_r[j-1];
      assign root_in[j] = root_r[j-1];
      assign rad_in[j]  = rad_r[j-1];
      assign vld_in[j]  = vld_r[j-1];
    end

    always_comb begin
      pulled   = {rem_in[j][REM_W-3:0], rad_in[j][RAD_W-1-2*j -: 2]};
      trial    = {{(REM_W-ROOT_W-2){1'b0}}, root_in[j], 2'b01};
      ge       = (pulled >= trial);
      rem_nxt  = ge ? (pulled - trial) : pulled;
      root_nxt = {root_in[j][ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else begin
        vld_r[j] <= vld_in[j];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[j]  <= rem_nxt;
      root_r[j] <= root_nxt;
      rad_r[j]  <= rad_in[j];
    end
  end

  assign out_item.vld  = vld_r[ROOT_W-1];
  assign out_item.root = root_r[ROOT_W-1];

endmodule

[rtl/core/edp_div.sv]
`timescale 1ns / 1ps
module edp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  edp_pkg::dist_item_t        in_item,
  output logic                       out_valid,
  output logic [edp_pkg::ROOT_W-1:0] out_dist,
  output logic [edp_pkg::DEPTH_W-1:0] out_depth
);
  import edp_pkg::*;

  logic              pre_vld_r;
  logic [ROOT_W-1:0] pre_dist_r;
  logic [ROOT_W-1:0] pre_den_r;

  logic [DREM_W-1:0] drem_r [QUO_W];
  logic [QUO_W-1:0]  quo_r  [QUO_W];
  logic [ROOT_W-1:0] den_r  [QUO_W];
  logic [ROOT_W-1:0] dist_r [QUO_W];
  logic              vld_r  [QUO_W];

  logic [DREM_W-1:0] drem_in [QUO_W];
  logic [QUO_W-1:0]  quo_in  [QUO_W];
  logic [ROOT_W-1:0] den_in  [QUO_W];
  logic [ROOT_W-1:0] dist_in [QUO_W];
  logic              vld_in  [QUO_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
    end else begin
      pre_vld_r <= in_item.vld;
    end
  end

  always_ff @(posedge clk) begin
    pre_dist_r <= in_item.root;
    pre_den_r  <= in_item.root + ONE_Q8;
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DREM_W-1:0] shifted;
    logic [DREM_W-1:0] dcmp;
    logic              ge;
    logic [DREM_W-1:0] drem_nxt;
    logic [QUO_W-1:0]  quo_nxt;

    if (k == 0) begin : g_first
      assign drem_in[k] = DIV_SEED;
      assign quo_in[k]  = '0;
      assign den_in[k]  = pre_den_r;
      assign dist_in[k] = pre_dist_r;
      assign vld_in[k]  = pre_vld_r;
    end else begin : g_next
      assign drem_in[k] = drem_r[k-1];
      assign quo_in[k]  = quo_r[k-1];
      assign den_in[k]  = den_r[k-1];
      assign dist_in[k] = dist_r[k-1];
      assign vld_in[k]  = vld_r[k-1];
    end

    always_comb begin
      shifted  = {drem_in[k][DREM_W-2:0], 1'b0};
      dcmp     = {1'b0, den_in[k]};
      ge       = (shifted >= dcmp);
      drem_nxt = ge ? (shifted - dcmp) : shifted;
      quo_nxt  = {quo_in[k][QUO_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in[k];
      end
    end

    always_ff @(posedge clk) begin
      drem_r[k] <= drem_nxt;
      quo_r[k]  <= quo_nxt;
      den_r[k]  <= den_in[k];
      dist_r[k] <= dist_in[k];
    end
  end

  assign out_valid = vld_r[QUO_W-1];
  assign out_dist  = dist_r[QUO_W-1];
  assign out_depth = quo_r[QUO_W-1];

endmodule

[dv/euclidean_depth_point_tb.sv]
`timescale 1ns / 1ps
module euclidean_depth_point_tb;
  import edp_pkg::*;

  localparam int MAX_DIMS       = 4;
  localparam int REPORT_LIMIT   = 10;
  localparam int STALL_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int SECTIONS       = 6;
  localparam int SECTION_POINTS = 105;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST = '1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [ROOT_W-1:0]  distance_q8;
    logic [DEPTH_W-1:0] depth_q16;
  } depth_result_t;

  class depth_board;
    coord_t            center [NUM_CENTERS];
    logic [DIMS_W-1:0] dims;
    depth_result_t     pending [$];
    int                mismatches;
    int                checked;
    int                points;
    int                dims_seen;

    function new();
      foreach (center[i]) center[i] = '0;
      dims       = DIMS_RESET;
      mismatches = 0;
      checked    = 0;
      points     = 0;
      dims_seen  = 0;
    endfunction

    function void store_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
      case (idx)
        CFG_CENTER_0:    center[0] = data;
        CFG_CENTER_1:    center[1] = data;
        CFG_CENTER_2:    center[2] = data;
        CFG_CENTER_3:    center[3] = data;
        CFG_ACTIVE_DIMS: dims = data[DIMS_W-1:0];
        default: ;
      endcase
    endfunction

    function depth_result_t depth_of(coord_t p0, coord_t p1, coord_t p2, coord_t p3);
      coord_t          pt [NUM_CENTERS];
      longint unsigned sum;
      longint unsigned rad;
      longint unsigned root;
      longint unsigned probe;
      longint unsigned mag;
      int              n;
      depth_result_t   r;
      pt[0] = p0;
      pt[1] = p1;
      pt[2] = p2;
      pt[3] = p3;
      n = (dims > MAX_DIMS) ? MAX_DIMS : int'(dims);
      sum = 0;
      for (int i = 0; i < n; i++) begin
        if (pt[i] >= center[i])
          mag = longint'(pt[i]) - longint'(center[i]);
        else
          mag = longint'(center[i]) - longint'(pt[i]);
        sum += mag * mag;
      end
      rad   = sum << FRAC_W;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > rad) probe >>= 2;
      while (probe != 0) begin
        if (rad >= root + probe) begin
          rad  -= root + probe;
          root  = (root >> 1) + probe;
        end else begin
          root >>= 1;
        end
        probe >>= 2;
      end
      r.distance_q8 = root[ROOT_W-1:0];
      r.depth_q16   = DEPTH_W'((64'd1 << NUM_LOG2) / (longint'(ONE_Q8) + root));
      return r;
    endfunction

    function void note_point(coord_t p0, coord_t p1, coord_t p2, coord_t p3);
      dims_seen |= 1 << dims;
      points++;
      pending.push_back(depth_of(p0, p1, p2, p3));
    endfunction

    function void check_result(logic [ROOT_W-1:0] got_dist, logic [DEPTH_W-1:0] got_depth);
      depth_result_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: distance_q8=%0d depth_q16=%0d", got_dist, got_depth);
        return;
      end
      want = pending.pop_front();
      if (want.distance_q8 !== got_dist || want.depth_q16 !== got_depth) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result %0d: distance_q8 exp %0d got %0d, depth_q16 exp %0d got %0d",
                   checked, want.distance_q8, got_dist, want.depth_q16, got_depth);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  coord_t               in_coord_0;
  coord_t               in_coord_1;
  coord_t               in_coord_2;
  coord_t               in_coord_3;
  logic                 out_valid;
  logic [ROOT_W-1:0]    out_distance_q8;
  logic [DEPTH_W-1:0]   out_depth_q16;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0]   cfg_data;

  depth_board board = new();
  int         stall_cycles = 0;
  int         cfg_writes = 0;
  int         sender_idle [3] = '{26, 80, 0};

  euclidean_depth_point #(.MAX_DIMS(MAX_DIMS)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_coord_0      (in_coord_0),
    .in_coord_1      (in_coord_1),
    .in_coord_2      (in_coord_2),
    .in_coord_3      (in_coord_3),
    .out_valid       (out_valid),
    .out_distance_q8 (out_distance_q8),
    .out_depth_q16   (out_depth_q16),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (out_valid === 1'b1) board.check_result(out_distance_q8, out_depth_q16);
    if (start && busy === 1'b0) board.note_point(in_coord_0, in_coord_1, in_coord_2, in_coord_3);
    if (cfg_valid && cfg_ready === 1'b1) board.store_reg(cfg_index, cfg_data);
  end

  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1 || (cfg_valid && cfg_ready === 1'b1))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", stall_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_point(input coord_t p0, input coord_t p1, input coord_t p2,
                            input coord_t p3);
    start      <= 1'b1;
    in_coord_0 <= p0;
    in_coord_1 <= p1;
    in_coord_2 <= p2;
    in_coord_3 <= p3;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic idle_gaps(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    cfg_writes++;
    @(posedge clk);
  endtask

  function automatic coord_t rand_center();
    case ($urandom_range(3))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic coord_t rand_coord(coord_t c);
    int r;
    r = $urandom_range(99);
    if (r < 50) return coord_t'($urandom);
    if (r < 65) begin
      case ($urandom_range(3))
        0:       return 16'sh8000;
        1:       return 16'sh7FFF;
        2:       return 16'sh0000;
        default: return 16'shFFFF;
      endcase
    end
    if (r < 90) return coord_t'(int'(c) + int'($urandom_range(511)) - 256);
    return coord_t'(int'($urandom_range(255)) - 128);
  endfunction

  task automatic configure_random();
    int r;
    program_reg(CFG_CENTER_0, rand_center());
    program_reg(CFG_CENTER_1, rand_center());
    program_reg(CFG_CENTER_2, rand_center());
    program_reg(CFG_CENTER_3, rand_center());
    r = $urandom_range(15);
    if (r < 12)
      program_reg(CFG_ACTIVE_DIMS, COORD_W'(r % MAX_DIMS + 1));
    else if (r == 12)
      program_reg(CFG_ACTIVE_DIMS, '0);
    else
      program_reg(CFG_ACTIVE_DIMS, COORD_W'(r - 8));
    if ($urandom_range(2) == 0)
      program_reg(CFG_IDX_W'($urandom_range(CFG_LAST, CFG_ACTIVE_DIMS + 1)),
                  COORD_W'($urandom));
  endtask

  task automatic send_random(input int pct);
    idle_gaps(pct);
    send_point(rand_coord(board.center[0]), rand_coord(board.center[1]),
               rand_coord(board.center[2]), rand_coord(board.center[3]));
  endtask

  initial begin
    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_coord_0 <= '0;
    in_coord_1 <= '0;
    in_coord_2 <= '0;
    in_coord_3 <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_CENTER_0;
    cfg_data   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_point(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_point(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_point(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555);
    drain();

    program_reg(CFG_CENTER_0, 16'h7FFF);
    program_reg(CFG_CENTER_1, 16'h7FFF);
    program_reg(CFG_CENTER_2, 16'h7FFF);
    program_reg(CFG_CENTER_3, 16'h7FFF);
    program_reg(CFG_ACTIVE_DIMS, 16'd4);
    send_point(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_point(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    drain();

    program_reg(CFG_ACTIVE_DIMS, 16'd0);
    send_random(0);
    drain();
    program_reg(CFG_ACTIVE_DIMS, 16'd7);
    send_random(0);
    drain();
    program_reg(CFG_ACTIVE_DIMS, 16'd5);
    send_random(0);
    drain();

    program_reg(CFG_CENTER_0, 16'h8000);
    program_reg(CFG_ACTIVE_DIMS, 16'd1);
    send_point(16'sh7FFF, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
    drain();
    program_reg(CFG_ACTIVE_DIMS, 16'd2);
    send_random(0);
    drain();
    program_reg(CFG_ACTIVE_DIMS, 16'd3);
    send_random(0);
    drain();

    for (int i = CFG_ACTIVE_DIMS + 1; i <= CFG_LAST; i++)
      program_reg(CFG_IDX_W'(i), COORD_W'($urandom));
    send_random(0);

    for (int ph = 0; ph < 3; ph++) begin
      for (int s = 0; s < SECTIONS; s++) begin
        drain();
        configure_random();
        repeat (SECTION_POINTS) send_random(sender_idle[ph]);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("checked %0d results from %0d points, %0d register writes",
             board.checked, board.points, cfg_writes);
    $display("active counts used (one bit per count 7..0): %b, extreme centers and coords",
             board.dims_seen[7:0]);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

[euclidean_depth_point.f]
+incdir+rtl/core
rtl/core/edp_pkg.sv
rtl/core/edp_lane.sv
rtl/core/edp_sqrt.sv
rtl/core/edp_div.sv
rtl/core/euclidean_depth_point.sv
dv/euclidean_depth_point_tb.sv
